// ===== hdl/sequential_list_engine_macros.svh =====
// Assertion macros used by sle_checker.sv.
`ifndef SEQUENTIAL_LIST_ENGINE_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SLE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sle check failed: same-cycle implication");

// Consequent must hold at a later cycle than the antecedent.
`define SLE_ASSERT_LAT2(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
      else $error("sle check failed: two-cycle latency");

`endif

// ===== hdl/sle_pkg.sv =====
`timescale 1ns / 1ps

package sle_pkg;

   // list geometry
   localparam int DEPTH      = 64;
   localparam int ELEM_WIDTH = 16;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LEN_W      = $clog2(DEPTH + 1);
   localparam int POS_W      = 7;
   localparam int VAL_W      = 16;
   localparam int CNT_W      = 7;
   localparam int CMP_W      = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

   // readout reduction: cells grouped by eight, one register level per tree level
   localparam int GROUP     = 8;
   localparam int GRP_SHIFT = 3;
   localparam int NGROUPS   = (DEPTH + GROUP - 1) / GROUP;
   localparam int NCELLS    = NGROUPS * GROUP;

   typedef logic [ELEM_WIDTH-1:0] elem_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [LEN_W-1:0]      len_type;
   typedef logic [CMP_W-1:0]      cmp_type;
   typedef logic [GRP_SHIFT-1:0]  off_type;

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_INSERT = 3'd1,
      OP_DELETE = 3'd2,
      OP_GET    = 3'd3,
      OP_LOCATE = 3'd4
   } op_type;

   typedef struct packed {
      logic [2:0]       operation;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic             ok;
      logic [VAL_W-1:0] read_value;
      logic [CNT_W-1:0] found_position;
      logic [CNT_W-1:0] count;
      logic             is_empty;
   } rsp_word_type;

   // broadcast from the control to every cell
   typedef struct packed {
      logic     shift_up;
      logic     shift_down;
      idx_type  slot;
      elem_type key;
      len_type  length;
   } cell_cmd_type;

endpackage

// ===== hdl/sequential_list_engine.sv =====
`timescale 1ns / 1ps

// Ordered list of up to sle_pkg::DEPTH elements held in a row of cells.
// A word is taken when start is high and busy is low; busy is low except in
// the first cycle after reset, so a new word can be taken every cycle. Each
// word gives exactly one result word, shown with rsp_strobe once the accept
// has passed through s1_valid_ff and rsp_strobe_ff; the receiver cannot
// stall, so it must take the result in that cycle. Insert and delete shift
// all cells together; get and locate compare all cells at once and fold the
// answers through a two-level registered tree over groups of eight cells.
// Stored elements are not cleared by reset or by clear; only the length is.
module sequential_list_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  sle_pkg::req_word_type req_word,
   output logic                  rsp_strobe,
   output sle_pkg::rsp_word_type rsp_word
);

   logic                  accept;
   logic                  busy_ff;
   sle_pkg::len_type      len_ff, len_in;
   sle_pkg::cmp_type      pos_ext, len_ext;
   logic                  pos_nonzero, ins_ok, rd_ok, del_ok;
   logic                  is_clear, is_locate;
   sle_pkg::cell_cmd_type cmd;

   sle_pkg::elem_type     cell_data [sle_pkg::NCELLS];
   logic                  cell_hit  [sle_pkg::NCELLS];
   logic                  cell_sel  [sle_pkg::NCELLS];

   sle_pkg::elem_type     grp_rd_in [sle_pkg::NGROUPS];
   logic                  grp_hit_in[sle_pkg::NGROUPS];
   sle_pkg::off_type      grp_off_in[sle_pkg::NGROUPS];
   sle_pkg::elem_type     grp_rd_ff [sle_pkg::NGROUPS];
   logic                  grp_hit_ff[sle_pkg::NGROUPS];
   sle_pkg::off_type      grp_off_ff[sle_pkg::NGROUPS];

   logic                  s1_valid_ff, s1_ok_ff, s1_locate_ff, s1_rd_en_ff;
   sle_pkg::len_type      s1_len_ff;

   logic                  any_hit;
   sle_pkg::len_type      found_idx;
   sle_pkg::elem_type     rd_fold;
   sle_pkg::rsp_word_type rsp_in, rsp_word_ff;
   logic                  rsp_strobe_ff;

   assign accept = start && !busy_ff;
   assign busy   = busy_ff;

   // request decode and range checks
   assign pos_ext     = sle_pkg::cmp_type'(req_word.position);
   assign len_ext     = sle_pkg::cmp_type'(len_ff);
   assign pos_nonzero = (req_word.position != '0);
   assign is_clear    = (req_word.operation == sle_pkg::OP_CLEAR);
   assign is_locate   = (req_word.operation == sle_pkg::OP_LOCATE);
   assign ins_ok      = (req_word.operation == sle_pkg::OP_INSERT) && pos_nonzero
                        && (pos_ext <= len_ext + sle_pkg::cmp_type'(1))
                        && (len_ext < sle_pkg::cmp_type'(sle_pkg::DEPTH));
   assign rd_ok       = ((req_word.operation == sle_pkg::OP_DELETE)
                         || (req_word.operation == sle_pkg::OP_GET))
                        && pos_nonzero && (pos_ext <= len_ext);
   assign del_ok      = (req_word.operation == sle_pkg::OP_DELETE) && rd_ok;

   // broadcast to the cells
   always_comb begin
      cmd.shift_up   = accept && ins_ok;
      cmd.shift_down = accept && del_ok;
      cmd.slot       = sle_pkg::idx_type'(pos_ext - sle_pkg::cmp_type'(1));
      cmd.key        = sle_pkg::elem_type'(req_word.value);
      cmd.length     = len_ff;
   end

   // next length
   always_comb begin
      len_in = len_ff;
      if (is_clear) begin
         len_in = '0;
      end else if (ins_ok) begin
         len_in = len_ff + sle_pkg::len_type'(1);
      end else if (del_ok) begin
         len_in = len_ff - sle_pkg::len_type'(1);
      end
   end

   // row of cells; ends and padding read as zero
   for (genvar i = 0; i < sle_pkg::NCELLS; i++) begin : g_cell
      if (i < sle_pkg::DEPTH) begin : g_live
         sle_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .cell_index (sle_pkg::idx_type'(i)),
            .left_data  ((i == 0) ? '0 : cell_data[(i == 0) ? 0 : i - 1]),
            .right_data ((i == sle_pkg::DEPTH - 1) ? '0
                         : cell_data[(i == sle_pkg::DEPTH - 1) ? i : i + 1]),
            .data       (cell_data[i]),
            .hit        (cell_hit[i]),
            .sel        (cell_sel[i])
         );
      end else begin : g_pad
         assign cell_data[i] = '0;
         assign cell_hit[i]  = 1'b0;
         assign cell_sel[i]  = 1'b0;
      end
   end

   // first level: per group of eight, first hit and selected element
   always_comb begin
      for (int g = 0; g < sle_pkg::NGROUPS; g++) begin
         grp_rd_in[g]  = '0;
         grp_hit_in[g] = 1'b0;
         grp_off_in[g] = '0;
         for (int k = sle_pkg::GROUP - 1; k >= 0; k--) begin
            if (cell_sel[g * sle_pkg::GROUP + k]) begin
               grp_rd_in[g] = grp_rd_in[g] | cell_data[g * sle_pkg::GROUP + k];
            end
            if (cell_hit[g * sle_pkg::GROUP + k]) begin
               grp_hit_in[g] = 1'b1;
               grp_off_in[g] = sle_pkg::off_type'(k);
            end
         end
      end
   end

   // second level: lowest group with a hit
   always_comb begin
      any_hit   = 1'b0;
      found_idx = '0;
      rd_fold   = '0;
      for (int g = sle_pkg::NGROUPS - 1; g >= 0; g--) begin
         rd_fold = rd_fold | grp_rd_ff[g];
         if (grp_hit_ff[g]) begin
            any_hit   = 1'b1;
            found_idx = (sle_pkg::len_type'(g) << sle_pkg::GRP_SHIFT)
                        | sle_pkg::len_type'(grp_off_ff[g]);
         end
      end
   end

   // result word
   always_comb begin
      rsp_in.ok             = s1_locate_ff ? any_hit : s1_ok_ff;
      rsp_in.read_value     = s1_rd_en_ff ? sle_pkg::VAL_W'(rd_fold) : '0;
      rsp_in.found_position = (s1_locate_ff && any_hit)
                              ? sle_pkg::CNT_W'(found_idx + sle_pkg::len_type'(1)) : '0;
      rsp_in.count          = sle_pkg::CNT_W'(s1_len_ff);
      rsp_in.is_empty       = (s1_len_ff == '0);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         len_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         if (accept) begin
            len_ff <= len_in;
         end
         s1_valid_ff   <= accept;
         rsp_strobe_ff <= s1_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      grp_rd_ff    <= grp_rd_in;
      grp_hit_ff   <= grp_hit_in;
      grp_off_ff   <= grp_off_in;
      s1_ok_ff     <= is_clear || ins_ok || rd_ok;
      s1_locate_ff <= is_locate;
      s1_rd_en_ff  <= rd_ok;
      s1_len_ff    <= len_in;
      rsp_word_ff  <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule

// ===== hdl/sle_cell.sv =====
`timescale 1ns / 1ps

// One list slot: holds an element, shifts to or from its neighbors,
// compares against the broadcast key.
module sle_cell (
   input  logic                 clock,
   input  sle_pkg::cell_cmd_type cmd,
   input  sle_pkg::idx_type     cell_index,
   input  sle_pkg::elem_type    left_data,
   input  sle_pkg::elem_type    right_data,
   output sle_pkg::elem_type    data,
   output logic                 hit,
   output logic                 sel
);

   sle_pkg::elem_type data_ff, data_in;

   // insert opens a gap at the slot, delete closes it
   always_comb begin
      data_in = data_ff;
      if (cmd.shift_up) begin
         if (cell_index > cmd.slot) begin
            data_in = left_data;
         end else if (cell_index == cmd.slot) begin
            data_in = cmd.key;
         end
      end else if (cmd.shift_down && (cell_index >= cmd.slot)) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign sel  = (cell_index == cmd.slot);
   // match only inside the live part of the list
   assign hit  = (sle_pkg::len_type'(cell_index) < cmd.length) && (data_ff == cmd.key);

endmodule

// ===== hdl/sle_checker.sv =====
`timescale 1ns / 1ps
`include "sequential_list_engine_macros.svh"

// Port-level checks on the list engine.
module sle_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_strobe,
   input sle_pkg::rsp_word_type rsp_word
);

   // every accepted word is answered with rsp_strobe
   `SLE_ASSERT_LAT2(a_rsp_follows, clock, reset, start && !busy, rsp_strobe)

   // no result without an earlier accepted word
   `SLE_ASSERT_NOW(a_no_spurious, clock, reset, rsp_strobe, $past(start && !busy, 2))

   // a rejected operation reports no data
   `SLE_ASSERT_NOW(a_reject_clean, clock, reset, rsp_strobe && !rsp_word.ok,
                   (rsp_word.read_value == '0) && (rsp_word.found_position == '0))

   // a nonzero found position means a successful locate
   `SLE_ASSERT_NOW(a_found_ok, clock, reset, rsp_strobe && (rsp_word.found_position != '0),
                   rsp_word.ok && (rsp_word.read_value == '0))

endmodule

bind sequential_list_engine sle_checker u_sle_checker (.*);
